FILE: rtl/madp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madp_pkg: shared types and constants
// Widths of the word size and shift counts, and the control bundle that
// travels beside the data through the pipeline.
// ----------------------------------------------------------------------------
package madp_pkg;

    // Word size register width, and width of every shift count derived from it.
    localparam int CNT_W = 5;

    // Word size after reset.
    localparam logic [CNT_W-1:0] WORD_LEN_RESET = 5'd16;

    // Control bundle that travels with each beat down the pipeline.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] n;
    } madp_ctrl_t;

endpackage

FILE: rtl/madp_mul_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madp_mul_stage: first pipeline stage
// Forms the product of the two input differences, merges them for the
// trailing zero count and saturates the word size at the data width.
// ----------------------------------------------------------------------------
module madp_mul_stage #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [31:0]                       diff_a,
    input  logic [31:0]                       diff_b,
    input  logic [31:0]                       diff_out,
    input  logic [madp_pkg::CNT_W-1:0]        word_len,
    output madp_pkg::madp_ctrl_t              ctrl,
    output logic [DATA_WIDTH-1:0]             prod,
    output logic [DATA_WIDTH-1:0]             diff_c,
    output logic [DATA_WIDTH-1:0]             merged
);
    import madp_pkg::*;

    logic [DATA_WIDTH-1:0] da;
    logic [DATA_WIDTH-1:0] db;
    logic [CNT_W-1:0]      n_sat;
    madp_ctrl_t            ctrl_reg;
    madp_ctrl_t            ctrl_next;
    logic [DATA_WIDTH-1:0] prod_reg;
    logic [DATA_WIDTH-1:0] diff_c_reg;
    logic [DATA_WIDTH-1:0] merged_reg;

    assign da = diff_a[DATA_WIDTH-1:0];
    assign db = diff_b[DATA_WIDTH-1:0];

    // The word size never exceeds the data width.
    always_comb
    begin
        if ({1'b0, word_len} > (CNT_W+1)'(DATA_WIDTH))
        begin
            n_sat = CNT_W'(DATA_WIDTH);
        end
        else
        begin
            n_sat = word_len;
        end
        ctrl_next.valid = in_valid;
        ctrl_next.n     = n_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Trailing zeros of the smaller count equal those of the bitwise OR.
    always_ff @(posedge clk)
    begin
        prod_reg   <= da * db;
        diff_c_reg <= diff_out[DATA_WIDTH-1:0];
        merged_reg <= da | db;
    end

    assign ctrl   = ctrl_reg;
    assign prod   = prod_reg;
    assign diff_c = diff_c_reg;
    assign merged = merged_reg;

endmodule

FILE: rtl/madp_tz_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madp_tz_stage: second pipeline stage
// Counts trailing zeros of the merged differences, saturated at the word
// size, and forms the wrapped residual of the product difference.
// ----------------------------------------------------------------------------
module madp_tz_stage #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  madp_pkg::madp_ctrl_t              ctrl_in,
    input  logic [DATA_WIDTH-1:0]             prod,
    input  logic [DATA_WIDTH-1:0]             diff_c,
    input  logic [DATA_WIDTH-1:0]             merged,
    output madp_pkg::madp_ctrl_t              ctrl,
    output logic [DATA_WIDTH-1:0]             resid,
    output logic [madp_pkg::CNT_W-1:0]        k
);
    import madp_pkg::*;

    logic [DATA_WIDTH-1:0] lowest;
    logic [CNT_W-1:0]      tz;
    logic [CNT_W-1:0]      k_next;
    madp_ctrl_t            ctrl_reg;
    logic [DATA_WIDTH-1:0] resid_reg;
    logic [CNT_W-1:0]      k_reg;

    // Isolate the lowest set bit, then encode its position.
    always_comb
    begin
        lowest = merged & (~merged + DATA_WIDTH'(1));
        tz     = '0;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            tz = tz | (lowest[i] ? CNT_W'(i) : '0);
        end
        if ((merged == '0) || (tz >= ctrl_in.n))
        begin
            k_next = ctrl_in.n;
        end
        else
        begin
            k_next = tz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        resid_reg <= diff_c - prod;
        k_reg     <= k_next;
    end

    assign ctrl  = ctrl_reg;
    assign resid = resid_reg;
    assign k     = k_reg;

endmodule

FILE: rtl/madp_check_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madp_check_stage: third pipeline stage and output register
// Tests the low bits of the residual and forms the divisor and shift.
// ----------------------------------------------------------------------------
module madp_check_stage #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  madp_pkg::madp_ctrl_t              ctrl_in,
    input  logic [DATA_WIDTH-1:0]             resid,
    input  logic [madp_pkg::CNT_W-1:0]        k,
    output logic                              done,
    output logic                              possible,
    output logic [31:0]                       common_divisor,
    output logic [madp_pkg::CNT_W-1:0]        prob_shift
);
    import madp_pkg::*;

    logic [DATA_WIDTH-1:0] low_mask;
    logic                  ok_next;
    logic [CNT_W-1:0]      shift_next;
    logic                  done_reg;
    logic                  possible_reg;
    logic [31:0]           divisor_reg;
    logic [CNT_W-1:0]      shift_reg;

    // A shift of the full data width wraps the mask round to all ones.
    always_comb
    begin
        low_mask   = (DATA_WIDTH'(1) << k) - DATA_WIDTH'(1);
        ok_next    = ((resid & low_mask) == '0);
        shift_next = ok_next ? (ctrl_in.n - k) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        possible_reg <= ok_next;
        divisor_reg  <= 32'd1 << k;
        shift_reg    <= shift_next;
    end

    assign done           = done_reg;
    assign possible       = possible_reg;
    assign common_divisor = divisor_reg;
    assign prob_shift     = shift_reg;

endmodule

FILE: rtl/mul_add_difference_probability.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mul_add_difference_probability: additive differential probability of
// modular multiplication, as a three-stage pipeline.
// A beat accepted on start passes through the multiply, trailing zero and
// check stage registers onto the ports, marked by done; throughput is one
// beat a cycle, since every stage advances on every cycle.
// busy is held low, since the receiver cannot stall and nothing waits.
// Reset clears the stage valid bits and sets the word size to 16.
// ----------------------------------------------------------------------------
module mul_add_difference_probability #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_wr_en,
    input  logic [madp_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic [31:0]                       diff_a,
    input  logic [31:0]                       diff_b,
    input  logic [31:0]                       diff_out,
    output logic                              done,
    output logic                              possible,
    output logic [31:0]                       common_divisor,
    output logic [madp_pkg::CNT_W-1:0]        prob_shift
);
    import madp_pkg::*;

    // The word size register is sampled with every accepted beat, and the
    // saturated value then travels down the pipeline beside the data.
    logic [CNT_W-1:0]      word_len_reg;
    logic [CNT_W-1:0]      word_len_next;
    logic                  accept;

    madp_ctrl_t            a_ctrl;
    logic [DATA_WIDTH-1:0] a_prod;
    logic [DATA_WIDTH-1:0] a_diff_c;
    logic [DATA_WIDTH-1:0] a_merged;

    madp_ctrl_t            b_ctrl;
    logic [DATA_WIDTH-1:0] b_resid;
    logic [CNT_W-1:0]      b_k;

    // Every stage moves on each cycle, so a new beat may always enter.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        word_len_next = cfg_wr_en ? cfg_wr_data : word_len_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg <= WORD_LEN_RESET;
        end
        else
        begin
            word_len_reg <= word_len_next;
        end
    end

    // First stage: the product and the merged differences.
    madp_mul_stage #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .diff_a    (diff_a),
        .diff_b    (diff_b),
        .diff_out  (diff_out),
        .word_len  (word_len_reg),
        .ctrl      (a_ctrl),
        .prod      (a_prod),
        .diff_c    (a_diff_c),
        .merged    (a_merged)
    );

    // Second stage: the saturated trailing zero count and the residual.
    madp_tz_stage #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_tz (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (a_ctrl),
        .prod    (a_prod),
        .diff_c  (a_diff_c),
        .merged  (a_merged),
        .ctrl    (b_ctrl),
        .resid   (b_resid),
        .k       (b_k)
    );

    // Third stage: the divisibility test, registered straight onto the ports.
    madp_check_stage #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl_in        (b_ctrl),
        .resid          (b_resid),
        .k              (b_k),
        .done           (done),
        .possible       (possible),
        .common_divisor (common_divisor),
        .prob_shift     (prob_shift)
    );

    // A beat in the first stage reaches the second on the next edge.
    a_to_b_chk: assert property (@(posedge clk) disable iff (!rst_n)
        a_ctrl.valid |=> b_ctrl.valid)
        else $error("beat lost between first and second stage");

    // A beat in the second stage is delivered on the next edge.
    b_to_out_chk: assert property (@(posedge clk) disable iff (!rst_n)
        b_ctrl.valid |=> done)
        else $error("beat lost before the output register");

    // The divisor is always a single power of two.
    divisor_chk: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot(common_divisor))
        else $error("common divisor is not a power of two");

    // An impossible transition reports no shift.
    shift_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !possible) |-> (prob_shift == '0))
        else $error("shift given for an impossible transition");

endmodule
